/* design/drn_pkg.sv */
// shared constants and types for the dense identifier renumbering block
`default_nettype none

package drn_pkg;

  // fixed field widths
  localparam int ID_W   = 8;
  localparam int CFG_W  = 7;
  localparam int RANK_W = 8;

  // column count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

  // depths of the input queue and the result queue
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  // one renumbered result
  typedef struct packed {
    logic [RANK_W-1:0] new_id;
    logic              last;
  } out_item_t;

endpackage

`default_nettype wire

/* design/drn_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module drn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/drn_fifo.sv */
// small register fifo with occupancy count
`default_nettype none

module drn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/drn_front.sv */
// front end: column count register, identifier folding and batch tracking
`default_nettype none

module drn_front #(
  parameter int MAX_COLS = 64,
  parameter int ID_RANGE = 256,
  localparam int MAP_N = (ID_RANGE < 2**drn_pkg::ID_W) ? ID_RANGE : 2**drn_pkg::ID_W,
  localparam int MW = $clog2(MAP_N),
  localparam int AW = $clog2(MAX_COLS),
  localparam int QW = MW + AW + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [drn_pkg::ID_W-1:0]   group_id,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [drn_pkg::CFG_W-1:0]  cfg_data,
  output logic                       q_push,
  output logic [QW-1:0]              q_din,
  input  logic                       q_full
);

  import drn_pkg::*;

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] column_count;
  logic [CNT_W-1:0] load_count;
  logic [MW-1:0]    mod_tab [2**ID_W];
  logic [EW-1:0]    cc_ext;
  logic [EW-1:0]    eff;
  logic [EW-1:0]    cnt_inc;
  logic             batch_end;

  // identifier folding table
  for (genvar i = 0; i < 2**ID_W; i++) begin : g_mod
    localparam int ModVal = i % ID_RANGE;
    assign mod_tab[i] = MW'(ModVal);
  end

  // effective batch length and end of batch detection
  always_comb begin
    cc_ext = EW'(column_count);
    if (cc_ext == '0) begin
      eff = EW'(1);
    end else if (cc_ext > EW'(MAX_COLS)) begin
      eff = EW'(MAX_COLS);
    end else begin
      eff = cc_ext;
    end
    cnt_inc   = EW'(load_count) + EW'(1);
    batch_end = (cnt_inc >= eff);
  end

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign q_push    = push & ~q_full;
  assign q_din     = {mod_tab[group_id], load_count[AW-1:0], batch_end};

  // config register and load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CFG_RESET;
      load_count   <= '0;
    end else begin
      if (cfg_valid) begin
        column_count <= cfg_data;
      end
      if (q_push) begin
        load_count <= batch_end ? '0 : cnt_inc[CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* design/drn_back.sv */
// back end: identifier store, presence map, rank scan and emit pipeline
`default_nettype none

module drn_back #(
  parameter int MAX_COLS = 64,
  parameter int ID_RANGE = 256,
  localparam int MAP_N = (ID_RANGE < 2**drn_pkg::ID_W) ? ID_RANGE : 2**drn_pkg::ID_W,
  localparam int MW = $clog2(MAP_N),
  localparam int AW = $clog2(MAX_COLS),
  localparam int QW = MW + AW + 1,
  localparam int OCW = $clog2(drn_pkg::OUT_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [QW-1:0]       q_dout,
  input  logic [OCW-1:0]      out_count,
  output logic                out_push,
  output drn_pkg::out_item_t  out_din
);

  import drn_pkg::*;

  back_state_t       state;
  logic [MW-1:0]     q_id;
  logic [AW-1:0]     q_idx;
  logic              q_last;
  logic [MAP_N-1:0]  present;
  logic [AW-1:0]     last_idx;
  logic [MW-1:0]     scan_idx;
  logic [RANK_W-1:0] running;
  logic [AW-1:0]     e_cnt;
  logic              issuing;
  logic              v1;
  logic              v2;
  logic              last1;
  logic              last2;
  logic [OCW:0]      occ;
  logic              room;
  logic              issue;
  logic              scan_we;
  logic [MW-1:0]     id_rd;
  logic [RANK_W-1:0] rank_rd;

  assign {q_id, q_idx, q_last} = q_dout;

  // handshake with the input queue and the output queue
  assign q_pop   = (state == ST_LOAD) && !q_empty;
  assign scan_we = (state == ST_SCAN);
  assign occ     = {1'b0, out_count} + (OCW + 1)'(v1) + (OCW + 1)'(v2);
  assign room    = (occ < (OCW + 1)'(OUT_DEPTH));
  assign issue   = (state == ST_EMIT) && issuing && room;

  assign out_push       = v2;
  assign out_din.new_id = rank_rd;
  assign out_din.last   = last2;

  // identifiers in load order
  drn_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_COLS)
  ) u_id_ram (
    .clk   (clk),
    .we    (q_pop),
    .waddr (q_idx),
    .wdata (q_id),
    .raddr (e_cnt),
    .rdata (id_rd)
  );

  // dense rank for every identifier value
  drn_ram #(
    .WIDTH (RANK_W),
    .DEPTH (MAP_N)
  ) u_rank_ram (
    .clk   (clk),
    .we    (scan_we),
    .waddr (scan_idx),
    .wdata (running),
    .raddr (id_rd),
    .rdata (rank_rd)
  );

  // sequencer: load, scan presence map, emit ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      present <= '0;
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1    <= issue;
      v2    <= v1;
      last1 <= (e_cnt == last_idx);
      last2 <= last1;
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            // first identifier of a batch starts a fresh map
            present <= ((q_idx == '0) ? '0 : present) | (MAP_N'(1) << q_id);
            if (q_last) begin
              last_idx <= q_idx;
              scan_idx <= '0;
              running  <= '0;
              state    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          running  <= running + RANK_W'(present[scan_idx]);
          scan_idx <= scan_idx + MW'(1);
          if (scan_idx == MW'(MAP_N - 1)) begin
            e_cnt   <= '0;
            issuing <= 1'b1;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (issue) begin
            e_cnt <= e_cnt + AW'(1);
            if (e_cnt == last_idx) begin
              issuing <= 1'b0;
            end
          end
          if (v2 && last2) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dense_id_renumber_core.sv */
// Dense rank renumbering of batches of group identifiers.
// Loading takes one identifier per cycle while full is low. The first result of a batch waits
// until its last identifier is loaded and the presence map scan over all MAP_N identifier values
// (MAP_N = min(ID_RANGE, 256)) is done, then results flow one per cycle while the result queue has room.
// Synchronous reset clears queues, the load counter and presence map; column_count returns to 1.
`default_nettype none

module dense_id_renumber_core #(
  parameter int MAX_COLS = 64,
  parameter int ID_RANGE = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [drn_pkg::ID_W-1:0]    group_id,
  output logic                        empty,
  input  logic                        pop,
  output logic [drn_pkg::RANK_W-1:0]  new_id,
  output logic                        last_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [drn_pkg::CFG_W-1:0]   cfg_data
);

  import drn_pkg::*;

  localparam int MAP_N = (ID_RANGE < 2**ID_W) ? ID_RANGE : 2**ID_W;
  localparam int MW    = $clog2(MAP_N);
  localparam int AW    = $clog2(MAX_COLS);
  localparam int QW    = MW + AW + 1;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic          q_push;
  logic [QW-1:0] q_din;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_dout;
  logic [OCW-1:0] out_count;
  logic          out_push;
  out_item_t     out_din;
  out_item_t     out_dout;

  // front end
  drn_front #(
    .MAX_COLS (MAX_COLS),
    .ID_RANGE (ID_RANGE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .group_id  (group_id),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  // queue between front and back
  drn_fifo #(
    .WIDTH (QW),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full),
    .count ()
  );

  // back end
  drn_back #(
    .MAX_COLS (MAX_COLS),
    .ID_RANGE (ID_RANGE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_dout    (q_dout),
    .out_count (out_count),
    .out_push  (out_push),
    .out_din   (out_din)
  );

  // result queue
  drn_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_din),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty),
    .full  (),
    .count (out_count)
  );

  assign new_id   = out_dout.new_id;
  assign last_out = out_dout.last;

endmodule

`default_nettype wire
